@@ src/smvs_pkg.sv @@
// ----------------------------------------------------------------------------
// smvs_pkg: shared types and sizes of the sample set statistics block
// Widths of the sample, sum, sum of squares, variance and root datapaths.
// ----------------------------------------------------------------------------
package smvs_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 34;
  localparam int DEV_W    = SAMPLE_W + 1;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SQ_W     = PROD_W + ADDR_W;
  localparam int VAR_W    = 48;
  localparam int STD_W    = 25;
  localparam int ROOT_W   = VAR_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int CSU_W    = ROOT_W + 3;
  localparam int STEP_W   = $clog2(SQ_W + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [SQ_W-1:0]            sq_t;
  typedef logic [VAR_W-1:0]           var_t;
  typedef logic [STD_W-1:0]           std_t;
  typedef logic [CSU_W-1:0]           csu_t;

endpackage

@@ src/smvs_in_if.sv @@
// ----------------------------------------------------------------------------
// smvs_in_if: sample channel
// Valid/ready channel carrying one sample and its end-of-set mark per word.
// ----------------------------------------------------------------------------
interface smvs_in_if;
  import smvs_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

@@ src/smvs_out_if.sv @@
// ----------------------------------------------------------------------------
// smvs_out_if: result channel
// Valid/ready channel carrying the statistics of one finished set per word.
// ----------------------------------------------------------------------------
interface smvs_out_if;
  import smvs_pkg::*;

  logic    valid;
  logic    ready;
  count_t  sample_count;
  sum_t    total;
  sample_t mean;
  var_t    variance;
  std_t    std_dev;
  logic    dropped;

  modport source (output valid, output sample_count, output total, output mean,
                  output variance, output std_dev, output dropped, input ready);
  modport sink (input valid, input sample_count, input total, input mean,
                input variance, input std_dev, input dropped, output ready);
endinterface

@@ src/smvs_store.sv @@
// ----------------------------------------------------------------------------
// smvs_store: sample memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smvs_store (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  smvs_pkg::addr_t   wr_addr,
  input  smvs_pkg::sample_t wr_data,
  input  logic              rd_en,
  input  smvs_pkg::addr_t   rd_addr,
  output smvs_pkg::sample_t rd_data,
  output logic              rd_valid
);
  import smvs_pkg::*;

  sample_t mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

endmodule

@@ src/smvs_csu.sv @@
// ----------------------------------------------------------------------------
// smvs_csu: shared compare-subtract unit
// Trial subtraction used for every quotient bit and every root bit.
// ----------------------------------------------------------------------------
module smvs_csu (
  input  smvs_pkg::csu_t a,
  input  smvs_pkg::csu_t b,
  output logic           ge,
  output smvs_pkg::csu_t diff
);
  import smvs_pkg::*;

  logic [CSU_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[CSU_W];
  assign diff = wide[CSU_W-1:0];

endmodule

@@ src/smvs_sqacc.sv @@
// ----------------------------------------------------------------------------
// smvs_sqacc: squared deviation accumulator
// Deviation magnitude, registered square and running sum of squares.
// ----------------------------------------------------------------------------
module smvs_sqacc (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              rd_valid,
  input  smvs_pkg::sample_t rd_data,
  input  smvs_pkg::sample_t mean,
  output logic              busy,
  output smvs_pkg::sq_t     sq
);
  import smvs_pkg::*;

  logic signed [DEV_W-1:0] dev;
  logic [SAMPLE_W-1:0]     dev_mag;
  logic [SAMPLE_W-1:0]     mag;
  logic [PROD_W-1:0]       prod;
  logic                    mag_valid;
  logic                    prod_valid;

  assign dev     = DEV_W'(rd_data) - DEV_W'(mean);
  assign dev_mag = dev[DEV_W-1] ? SAMPLE_W'(-dev) : SAMPLE_W'(dev);
  assign busy    = mag_valid | prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      mag_valid  <= rd_valid;
      prod_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag  <= dev_mag;
    prod <= PROD_W'(mag) * PROD_W'(mag);
    if (clear) begin
      sq <= '0;
    end else if (prod_valid) begin
      sq <= sq + SQ_W'(prod);
    end
  end

endmodule

@@ src/sample_set_mean_variance_stddev.sv @@
// ----------------------------------------------------------------------------
// sample_set_mean_variance_stddev: two-pass mean, variance and deviation
// Samples are taken one word per cycle into a 1024-entry store while a count
// and a sum are kept; samples beyond capacity are dropped and flagged. After
// the word marked last the block stops taking words while it works through
// a set-up state, the mean division (one quotient bit per cycle), the second
// pass (one store read per cycle through a four-stage square-and-add pipe),
// the variance division and the square root, all bit steps on one shared
// compare-subtract unit, and then posts the result, held for as long as the
// previous result word is still waiting.
// Divisions truncate toward zero; the variance saturates at its maximum.
// ----------------------------------------------------------------------------
module sample_set_mean_variance_stddev (
  input logic       clk,
  input logic       rst,
  smvs_in_if.sink   data,
  smvs_out_if.source result
);
  import smvs_pkg::*;

  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_MDIV   = 7'b0000100,
    ST_PASS   = 7'b0001000,
    ST_VDIV   = 7'b0010000,
    ST_ROOT   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t            state, state_next;
  count_t            count, count_next;
  sum_t              sum, sum_next;
  logic              overflow, overflow_next;
  sample_t           mean, mean_next;
  sq_t               acc, acc_next;
  logic [REM_W-1:0]  rem, rem_next;
  logic [ROOT_W-1:0] root, root_next;
  var_t              var_q, var_next;
  logic [STEP_W-1:0] step, step_next;
  count_t            idx, idx_next;

  logic              out_valid;
  logic              out_load;
  count_t            res_count;
  sum_t              res_total;
  sample_t           res_mean;
  var_t              res_var;
  std_t              res_std;
  logic              res_dropped;

  logic              wr_en;
  logic              rd_en;
  sample_t           rd_data;
  logic              rd_valid;
  logic              sq_clear;
  logic              sq_busy;
  sq_t               sq;

  csu_t              csu_a;
  csu_t              csu_b;
  logic              csu_ge;
  csu_t              csu_diff;
  sq_t               acc_div;
  logic [SUM_W-1:0]  sum_mag;
  logic [SAMPLE_W-1:0] mean_mag;
  var_t              var_sat;

  smvs_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (count[ADDR_W-1:0]),
    .wr_data  (data.sample),
    .rd_en    (rd_en),
    .rd_addr  (idx[ADDR_W-1:0]),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  smvs_sqacc u_sqacc (
    .clk      (clk),
    .rst      (rst),
    .clear    (sq_clear),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .mean     (mean),
    .busy     (sq_busy),
    .sq       (sq)
  );

  smvs_csu u_csu (
    .a    (csu_a),
    .b    (csu_b),
    .ge   (csu_ge),
    .diff (csu_diff)
  );

  always_comb begin
    if (state == ST_ROOT) begin
      csu_a = {rem, acc[SQ_W-1:SQ_W-2]};
      csu_b = CSU_W'({root, 2'b01});
    end else begin
      csu_a = CSU_W'({rem, acc[SQ_W-1]});
      csu_b = CSU_W'(count);
    end
  end

  assign acc_div  = {acc[SQ_W-2:0], csu_ge};
  assign sum_mag  = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  assign mean_mag = acc_div[SAMPLE_W-1:0];
  assign var_sat  = (|acc_div[SQ_W-1:VAR_W]) ? '1 : acc_div[VAR_W-1:0];

  assign data.ready = (state == ST_LOAD);

  always_comb begin
    state_next    = state;
    count_next    = count;
    sum_next      = sum;
    overflow_next = overflow;
    mean_next     = mean;
    acc_next      = acc;
    rem_next      = rem;
    root_next     = root;
    var_next      = var_q;
    step_next     = step;
    idx_next      = idx;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    sq_clear      = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_LOAD: begin
        if (data.valid) begin
          if (count == COUNT_W'(MAX_SAMPLES)) begin
            overflow_next = 1'b1;
          end else begin
            wr_en      = 1'b1;
            count_next = count + COUNT_W'(1);
            sum_next   = sum + SUM_W'(data.sample);
          end
          if (data.last) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        acc_next   = {sum_mag, {(SQ_W-SUM_W){1'b0}}};
        rem_next   = '0;
        step_next  = STEP_W'(SUM_W - 1);
        state_next = ST_MDIV;
      end
      ST_MDIV: begin
        acc_next  = acc_div;
        rem_next  = csu_ge ? csu_diff[REM_W-1:0] : csu_a[REM_W-1:0];
        step_next = step - STEP_W'(1);
        if (step == '0) begin
          mean_next  = sum[SUM_W-1] ? sample_t'(~mean_mag + SAMPLE_W'(1))
                                    : sample_t'(mean_mag);
          idx_next   = '0;
          sq_clear   = 1'b1;
          state_next = ST_PASS;
        end
      end
      ST_PASS: begin
        if (idx != count) begin
          rd_en    = 1'b1;
          idx_next = idx + COUNT_W'(1);
        end else if (!rd_valid && !sq_busy) begin
          acc_next   = sq;
          rem_next   = '0;
          step_next  = STEP_W'(SQ_W - 1);
          state_next = ST_VDIV;
        end
      end
      ST_VDIV: begin
        acc_next  = acc_div;
        rem_next  = csu_ge ? csu_diff[REM_W-1:0] : csu_a[REM_W-1:0];
        step_next = step - STEP_W'(1);
        if (step == '0) begin
          var_next   = var_sat;
          acc_next   = {var_sat, {(SQ_W-VAR_W){1'b0}}};
          rem_next   = '0;
          root_next  = '0;
          step_next  = STEP_W'(ROOT_W - 1);
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        acc_next  = {acc[SQ_W-3:0], 2'b00};
        rem_next  = csu_ge ? csu_diff[REM_W-1:0] : csu_a[REM_W-1:0];
        root_next = {root[ROOT_W-2:0], csu_ge};
        step_next = step - STEP_W'(1);
        if (step == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          out_load      = 1'b1;
          count_next    = '0;
          sum_next      = '0;
          overflow_next = 1'b0;
          state_next    = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      sum       <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      sum      <= sum_next;
      overflow <= overflow_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mean  <= mean_next;
    acc   <= acc_next;
    rem   <= rem_next;
    root  <= root_next;
    var_q <= var_next;
    step  <= step_next;
    idx   <= idx_next;
    if (out_load) begin
      res_count   <= count;
      res_total   <= sum;
      res_mean    <= mean;
      res_var     <= var_q;
      res_std     <= STD_W'(root);
      res_dropped <= overflow;
    end
  end

  assign result.valid        = out_valid;
  assign result.sample_count = res_count;
  assign result.total        = res_total;
  assign result.mean         = res_mean;
  assign result.variance     = res_var;
  assign result.std_dev      = res_std;
  assign result.dropped      = res_dropped;

endmodule

@@ tb/sample_set_mean_variance_stddev_tb.sv @@
// ----------------------------------------------------------------------------
// sample_set_mean_variance_stddev_tb: self-checking bench for set statistics
// Sends sample sets through the input channel with random idle and stall
// cycles on both sides. A local model keeps the set and predicts count, sum,
// mean, variance, deviation and drop flag for each set. Every result word is
// checked in order against that prediction.
// ----------------------------------------------------------------------------
module sample_set_mean_variance_stddev_tb;
  import smvs_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 2500;
  localparam int RANDOM_WORDS = 450;
  localparam longint unsigned VAR_SAT = 64'h0000_FFFF_FFFF_FFFF;
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EXTREME, SPREAD_FINE} spread_t;

  typedef struct {
    count_t  sample_count;
    sum_t    total;
    sample_t mean;
    var_t    variance;
    std_t    std_dev;
    logic    dropped;
  } set_stats_t;

  logic clk;
  logic rst;

  smvs_in_if  data_ch ();
  smvs_out_if result_ch ();

  sample_set_mean_variance_stddev dut (
    .clk    (clk),
    .rst    (rst),
    .data   (data_ch),
    .result (result_ch)
  );

  sample_t     set_samples [MAX_SAMPLES];
  int unsigned set_count;
  longint      set_sum;
  bit          set_dropped;
  set_stats_t  pending_stats [$];

  int unsigned cycle_count = 0;
  int          hold_cycles = 0;
  bit          no_idle = 0;
  int          words_sent = 0;
  int          sets_done = 0;
  int          dropped_sets = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          hold_offs = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d sets still pending", cycle_count,
               pending_stats.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  task automatic fold_sample(input sample_t s, input logic last_flag);
    set_stats_t      st;
    longint          mean_v;
    longint          dev;
    longint unsigned prod;
    longint unsigned sq;
    longint unsigned var_v;
    if (set_count < MAX_SAMPLES) begin
      set_samples[set_count] = s;
      set_count++;
      set_sum += longint'(s);
    end else begin
      set_dropped = 1'b1;
    end
    if (last_flag) begin
      mean_v = 0;
      sq = 0;
      var_v = 0;
      if (set_count != 0) begin
        mean_v = set_sum / longint'(set_count);
        for (int i = 0; i < set_count; i++) begin
          dev = longint'(set_samples[i]) - mean_v;
          prod = longint'(dev * dev);
          sq = (sq > ~64'd0 - prod) ? ~64'd0 : sq + prod;
        end
        var_v = sq / longint'(set_count);
        if (var_v > VAR_SAT) var_v = VAR_SAT;
      end
      st.sample_count = count_t'(set_count);
      st.total = sum_t'(set_sum);
      st.mean = sample_t'(mean_v);
      st.variance = var_t'(var_v);
      st.std_dev = std_t'(root_floor(var_v));
      st.dropped = set_dropped;
      pending_stats.push_back(st);
      if (set_dropped) dropped_sets++;
      sets_done++;
      set_count = 0;
      set_sum = 0;
      set_dropped = 1'b0;
    end
  endtask

  function automatic void compare_field(string name, logic [63:0] exp_v,
                                        logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < 10)
        $display("mismatch on %s of result %0d: expected %0h, got %0h", name,
                 results_seen, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic check_stats_word();
    set_stats_t st;
    if (pending_stats.size() == 0) begin
      if (mismatches < 10)
        $display("result word %0d arrived with no set pending", results_seen);
      mismatches++;
    end else begin
      st = pending_stats.pop_front();
      compare_field("sample_count", 64'(st.sample_count), 64'(result_ch.sample_count));
      compare_field("total", 64'(st.total), 64'(result_ch.total));
      compare_field("mean", 64'(st.mean), 64'(result_ch.mean));
      compare_field("variance", 64'(st.variance), 64'(result_ch.variance));
      compare_field("std_dev", 64'(st.std_dev), 64'(result_ch.std_dev));
      compare_field("dropped", 64'(st.dropped), 64'(result_ch.dropped));
    end
    results_seen++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) check_stats_word();
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (!no_idle && $urandom_range(0, 99) < 35) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input sample_t s, input logic last_flag);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      data_ch.valid <= 1'b0;
      @(negedge clk);
    end
    data_ch.valid  <= 1'b1;
    data_ch.sample <= s;
    data_ch.last   <= last_flag;
    do @(posedge clk); while (data_ch.ready !== 1'b1);
    fold_sample(s, last_flag);
    words_sent++;
  endtask

  task automatic stop_input();
    @(negedge clk);
    data_ch.valid <= 1'b0;
  endtask

  task automatic send_set(input sample_t vals [$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  function automatic sample_t pick_sample(spread_t spread, int base);
    int v;
    v = 0;
    case (spread)
      SPREAD_FULL: return sample_t'($urandom);
      SPREAD_NEAR: v = base + int'($urandom_range(0, 511)) - 256;
      SPREAD_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 1023)) - 512;
    endcase
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    if (v < int'(SAMPLE_MIN)) v = int'(SAMPLE_MIN);
    return sample_t'(v);
  endfunction

  task automatic test_single_samples();
    send_set('{sample_t'(0)});
    send_set('{SAMPLE_MAX});
    send_set('{SAMPLE_MIN});
    send_set('{sample_t'(-1)});
  endtask

  task automatic test_extreme_pairs();
    send_set('{SAMPLE_MIN, SAMPLE_MAX});
    send_set('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
  endtask

  task automatic test_truncated_mean();
    send_set('{sample_t'(-1), sample_t'(-2)});
    send_set('{sample_t'(1), sample_t'(2)});
    send_set('{sample_t'(-5), sample_t'(3), sample_t'(1)});
  endtask

  task automatic test_mixed_set();
    send_set('{SAMPLE_MIN, SAMPLE_MAX, sample_t'(0), sample_t'(1), sample_t'(-1),
               sample_t'(256), sample_t'(-256), sample_t'(24'h155555),
               sample_t'(-24'sh2AAAAA)});
  endtask

  task automatic test_store_full();
    no_idle = 1;
    for (int i = 0; i < MAX_SAMPLES + 3; i++)
      send_word(i < MAX_SAMPLES ? sample_t'($urandom) : SAMPLE_MIN,
                i == MAX_SAMPLES + 2);
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    hold_cycles = HOLD_CYCLES;
    hold_offs++;
    for (int n = 0; n < 5; n++)
      for (int i = 0; i < 8; i++)
        send_word(sample_t'($urandom), i == 7);
  endtask

  task automatic test_random_sets();
    int      start_words;
    int      set_len;
    int      base;
    int      pick;
    spread_t spread;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) set_len = $urandom_range(1, 12);
      else if (pick < 95) set_len = $urandom_range(13, 64);
      else set_len = $urandom_range(65, 300);
      spread = spread_t'($urandom_range(0, 3));
      base = int'(sample_t'($urandom));
      for (int i = 0; i < set_len; i++)
        send_word(pick_sample(spread, base), i == set_len - 1);
    end
  endtask

  initial begin
    rst = 1'b1;
    data_ch.valid = 1'b0;
    data_ch.sample = '0;
    data_ch.last = 1'b0;
    set_count = 0;
    set_sum = 0;
    set_dropped = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_samples();
    test_extreme_pairs();
    test_truncated_mean();
    test_mixed_set();
    test_store_full();
    test_backpressure();
    test_random_sets();

    stop_input();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sets from %0d sample words, %0d of them over capacity",
             sets_done, words_sent, dropped_sets);
    $display("checked %0d result words across %0d receiver hold-offs, %0d mismatches",
             results_seen, hold_offs, mismatches);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
